// ===== design/egr_pkg.sv =====
// Shared constants, glyph table and controller/datapath types for the glyph rasterizer.
`timescale 1ns / 1ps

package egr_pkg;

  // Framebuffer row pitch in words.
  localparam int ROW_WIDTH   = 1024;
  // Number of glyphs in the table.
  localparam int GLYPH_COUNT = 64;
  // Depth runs while four times the step stays below this limit.
  localparam int DEPTH_LIMIT = 92;

  // Number of depth steps per row, and the counter width that holds them.
  localparam int DEPTH_STEPS = (DEPTH_LIMIT + 3) / 4;
  localparam int DEPTH_W     = $clog2(DEPTH_STEPS + 1);

  // Walk geometry.
  localparam int POS_W     = 8;
  localparam int ROW_STEP  = 5;
  localparam int SUB_ROWS  = 4;
  localparam int MAX_SHIFT = 6;

  // Input field widths.
  localparam int CODE_W  = 6;
  localparam int ORG_W   = 10;
  localparam int SHIFT_W = 3;
  localparam int GLYPH_W = 9;

  // Output field widths.
  localparam int INDEX_W = 32;
  localparam int COLOR_W = 24;

  // Colors.
  localparam logic [COLOR_W-1:0] COLOR_FRONT  = 24'hffffff;
  localparam logic [COLOR_W-1:0] COLOR_BOTTOM = 24'h080808;
  localparam logic [7:0]         GREY_TOP     = 8'h3f;

  // Action codes on the input channel.
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;

  // 3x3 glyph bitmaps, bit (col + 3*row).
  localparam logic [GLYPH_W-1:0] GLYPH_ROM [GLYPH_COUNT] = '{
    9'h000, 9'h089, 9'h02d, 9'h145, 9'h0fe, 9'h1ff, 9'h1eb, 9'h012,
    9'h19e, 9'h0f3, 9'h155, 9'h0ba, 9'h052, 9'h038, 9'h010, 9'h054,
    9'h1ef, 9'h1d3, 9'h193, 9'h1f7, 9'h13d, 9'h0d6, 9'h1f9, 9'h127,
    9'h1fe, 9'h13f, 9'h082, 9'h052, 9'h18e, 9'h1c7, 9'h0e3, 9'h077,
    9'h1aa, 9'h17a, 9'h1fb, 9'h1cf, 9'h0eb, 9'h1df, 9'h05f, 9'h1eb,
    9'h17d, 9'h1d7, 9'h1ec, 9'h15d, 9'h1c9, 9'h17f, 9'h16f, 9'h1ef,
    9'h07f, 9'h13f, 9'h04f, 9'h0d6, 9'h097, 9'h1ed, 9'h0ad, 9'h1fd,
    9'h155, 9'h095, 9'h193, 9'h1cf, 9'h111, 9'h1e7, 9'h02a, 9'h1c0
  };

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;   // capture a result into the output register
    logic start;  // latch a new glyph and clear the walk counters
    logic step;   // process one walk slot and advance the counters
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic walk_end;  // the current slot is the last one of the walk
  } status_t;

endpackage

// ===== design/extruded_glyph_rasterizer.sv =====
// Top level of the extruded glyph rasterizer: controller and datapath.
`timescale 1ns / 1ps

// Every input item, start or tick, yields exactly one result item in the cycle
// after it is accepted. The block takes one item per clock cycle: the
// address, cell lookup and shade of a walk slot are computed in the cycle the
// tick is accepted and land in a single output register, so a new item is
// taken whenever that register is empty or is being read in the same cycle.
// The sustained rate is therefore one item per cycle, set only by how fast
// the downstream side takes results. A start item aborts any walk in progress.
module extruded_glyph_rasterizer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // char_code[5:0], origin_x[15:6], origin_y[25:16],
                                  // scale_shift[28:26], zero[31:29]
  input  logic        in_tuser,   // action: 0 tick, 1 start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // pixel_index[31:0], pixel_color[55:32]
  output logic        out_tuser,  // write_enable
  output logic        out_tlast   // glyph_done
);

  egr_pkg::cmd_t    cmd;
  egr_pkg::status_t status;

  // Handshake and walk control.
  egr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_action  (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  // Pixel generation.
  egr_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .char_code    (in_tdata[5:0]),
    .origin_x     (in_tdata[15:6]),
    .origin_y     (in_tdata[25:16]),
    .scale_shift  (in_tdata[28:26]),
    .write_enable (out_tuser),
    .pixel_index  (out_tdata[31:0]),
    .pixel_color  (out_tdata[55:32]),
    .glyph_done   (out_tlast)
  );

endmodule

// ===== design/egr_ctrl.sv =====
// Controller: walk state, input/output handshake and datapath commands.
`timescale 1ns / 1ps

module egr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_action,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  egr_pkg::status_t  status,
  output egr_pkg::cmd_t     cmd
);

  egr_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= egr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Handshake, commands and next state.
  always_comb begin
    in_tready     = !out_valid_r || out_tready;
    accept        = in_tvalid && in_tready;
    cmd.load      = accept;
    cmd.start     = accept && (in_action == egr_pkg::ACT_START);
    cmd.step      = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = accept ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

    unique case (state_r)
      egr_pkg::ST_IDLE: begin
        if (cmd.start) begin
          state_nxt = egr_pkg::ST_WALK;
        end
      end
      egr_pkg::ST_WALK: begin
        cmd.step = accept && (in_action == egr_pkg::ACT_TICK);
        if (cmd.step && status.walk_end) begin
          state_nxt = egr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = egr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

// ===== design/egr_datapath.sv =====
// Datapath: glyph latch, walk counters, pixel address and shade, output register.
`timescale 1ns / 1ps

module egr_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  egr_pkg::cmd_t                     cmd,
  output egr_pkg::status_t                  status,
  input  logic [egr_pkg::CODE_W-1:0]        char_code,
  input  logic [egr_pkg::ORG_W-1:0]         origin_x,
  input  logic [egr_pkg::ORG_W-1:0]         origin_y,
  input  logic [egr_pkg::SHIFT_W-1:0]       scale_shift,
  output logic                              write_enable,
  output logic [egr_pkg::INDEX_W-1:0]       pixel_index,
  output logic [egr_pkg::COLOR_W-1:0]       pixel_color,
  output logic                              glyph_done
);

  logic [egr_pkg::GLYPH_W-1:0] glyph_r, glyph_nxt;
  logic [egr_pkg::ORG_W-1:0]   base_x_r, base_x_nxt;
  logic [egr_pkg::ORG_W-1:0]   base_y_r, base_y_nxt;
  logic [egr_pkg::SHIFT_W-1:0] shift_r, shift_nxt;
  logic [egr_pkg::POS_W-1:0]   col_r, col_nxt;
  logic [egr_pkg::POS_W-1:0]   row_r, row_nxt;
  logic [egr_pkg::DEPTH_W-1:0] dep_r, dep_nxt;
  logic [1:0]                  sub_r, sub_nxt;

  logic                        we_r;
  logic [egr_pkg::INDEX_W-1:0] idx_r;
  logic [egr_pkg::COLOR_W-1:0] color_r;
  logic                        done_r;

  logic [egr_pkg::POS_W:0]     gsize;
  logic [egr_pkg::POS_W:0]     row_next;
  logic [egr_pkg::POS_W:0]     col_next;
  logic [9:0]                  row_cell;
  logic [9:0]                  cell_idx;
  logic                        cell_set;
  logic                        last_sub;
  logic                        last_dep;
  logic                        last_row;
  logic                        last_col;
  logic [31:0]                 fx;
  logic [31:0]                 fy;
  logic [31:0]                 idx;
  logic [7:0]                  tri_d;
  logic [7:0]                  grey;
  logic [egr_pkg::COLOR_W-1:0] color;

  // Walk geometry and end-of-walk detection.
  always_comb begin
    gsize    = (9'd3 << shift_r) - 9'd1;
    row_next = {1'b0, row_r} + 9'(egr_pkg::ROW_STEP);
    col_next = {1'b0, col_r} + 9'd1;
    last_sub = (sub_r == 2'(egr_pkg::SUB_ROWS - 1));
    last_dep = (dep_r == egr_pkg::DEPTH_W'(egr_pkg::DEPTH_STEPS - 1));
    last_row = (row_next >= gsize);
    last_col = (col_next >= gsize);
    status.walk_end = last_sub && last_dep && last_row && last_col;
  end

  // Cell lookup in the 3x3 bitmap.
  always_comb begin
    row_cell = 10'(row_r >> shift_r);
    cell_idx = 10'(col_r >> shift_r) + (row_cell << 1) + row_cell;
    cell_set = (cell_idx < 10'd9) && glyph_r[cell_idx[3:0]];
  end

  // Pixel address with the diagonal depth offset.
  always_comb begin
    fx  = 32'(base_x_r) + 32'(col_r) + (32'(dep_r) << 1);
    fy  = 32'(base_y_r) + 32'(row_r) - 32'(col_r >> 2) + (32'(dep_r) << 1)
        + 32'(sub_r);
    idx = fx + fy * 32'(egr_pkg::ROW_WIDTH);
  end

  // Shade: white front face, fading grey depth, dark bottom rows.
  always_comb begin
    tri_d = (8'(dep_r) << 1) + 8'(dep_r);
    grey  = (tri_d > egr_pkg::GREY_TOP) ? 8'd0 : (egr_pkg::GREY_TOP - tri_d);
    if (dep_r == '0) begin
      color = egr_pkg::COLOR_FRONT;
    end else begin
      color = {grey, grey, grey};
    end
    if ((shift_r != '0) && ({1'b0, row_r} > (gsize - 9'd3))) begin
      color = egr_pkg::COLOR_BOTTOM;
    end
  end

  // Next values of the glyph latch and walk counters.
  always_comb begin
    glyph_nxt  = glyph_r;
    base_x_nxt = base_x_r;
    base_y_nxt = base_y_r;
    shift_nxt  = shift_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    dep_nxt    = dep_r;
    sub_nxt    = sub_r;
    if (cmd.start) begin
      glyph_nxt  = egr_pkg::GLYPH_ROM[char_code];
      base_x_nxt = origin_x;
      base_y_nxt = origin_y;
      shift_nxt  = (scale_shift > 3'(egr_pkg::MAX_SHIFT)) ?
                   3'(egr_pkg::MAX_SHIFT) : scale_shift;
      col_nxt    = '0;
      row_nxt    = '0;
      dep_nxt    = '0;
      sub_nxt    = '0;
    end else if (cmd.step) begin
      sub_nxt = sub_r + 2'd1;
      if (last_sub) begin
        sub_nxt = '0;
        dep_nxt = dep_r + egr_pkg::DEPTH_W'(1);
        if (last_dep) begin
          dep_nxt = '0;
          row_nxt = row_next[egr_pkg::POS_W-1:0];
          if (last_row) begin
            row_nxt = '0;
            col_nxt = col_next[egr_pkg::POS_W-1:0];
            if (last_col) begin
              col_nxt = '0;
            end
          end
        end
      end
    end
  end

  // Glyph latch and walk counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_r  <= '0;
      base_x_r <= '0;
      base_y_r <= '0;
      shift_r  <= '0;
      col_r    <= '0;
      row_r    <= '0;
      dep_r    <= '0;
      sub_r    <= '0;
    end else begin
      glyph_r  <= glyph_nxt;
      base_x_r <= base_x_nxt;
      base_y_r <= base_y_nxt;
      shift_r  <= shift_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      dep_r    <= dep_nxt;
      sub_r    <= sub_nxt;
    end
  end

  // Output register; a slot without a write carries zeros.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      we_r    <= cmd.step && cell_set;
      idx_r   <= (cmd.step && cell_set) ? idx : '0;
      color_r <= (cmd.step && cell_set) ? color : '0;
      done_r  <= cmd.step && status.walk_end;
    end
  end

  assign write_enable = we_r;
  assign pixel_index  = idx_r;
  assign pixel_color  = color_r;
  assign glyph_done   = done_r;

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the extruded glyph rasterizer stream block.
`timescale 1ns / 1ps

module tb_top;

  // Independent copies of the walk geometry and glyph table used by the predictor.
  localparam int unsigned FB_PITCH     = 1024;
  localparam int unsigned DEPTH_END    = 92;
  localparam int unsigned ROW_STRIDE   = 5;
  localparam int unsigned SUBROW_COUNT = 4;
  localparam int unsigned SHIFT_CAP    = 6;
  localparam logic [23:0] WHITE        = 24'hffffff;
  localparam logic [23:0] DARK_GREY    = 24'h080808;
  localparam int unsigned GREY_BASE    = 'h3f;

  // Codes that the directed tests refer to.
  localparam logic [5:0] CODE_EMPTY = 6'd0;
  localparam logic [5:0] CODE_FULL  = 6'd5;
  localparam logic [5:0] CODE_LAST  = 6'd63;

  localparam logic [8:0] GLYPH_TABLE [64] = '{
    9'h000, 9'h089, 9'h02d, 9'h145, 9'h0fe, 9'h1ff, 9'h1eb, 9'h012,
    9'h19e, 9'h0f3, 9'h155, 9'h0ba, 9'h052, 9'h038, 9'h010, 9'h054,
    9'h1ef, 9'h1d3, 9'h193, 9'h1f7, 9'h13d, 9'h0d6, 9'h1f9, 9'h127,
    9'h1fe, 9'h13f, 9'h082, 9'h052, 9'h18e, 9'h1c7, 9'h0e3, 9'h077,
    9'h1aa, 9'h17a, 9'h1fb, 9'h1cf, 9'h0eb, 9'h1df, 9'h05f, 9'h1eb,
    9'h17d, 9'h1d7, 9'h1ec, 9'h15d, 9'h1c9, 9'h17f, 9'h16f, 9'h1ef,
    9'h07f, 9'h13f, 9'h04f, 9'h0d6, 9'h097, 9'h1ed, 9'h0ad, 9'h1fd,
    9'h155, 9'h095, 9'h193, 9'h1cf, 9'h111, 9'h1e7, 9'h02a, 9'h1c0
  };

  typedef struct {
    logic        we;
    logic [31:0] idx;
    logic [23:0] color;
    logic        done;
  } pixel_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  extruded_glyph_rasterizer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Predicted walk state.
  bit          walk_busy;
  logic [8:0]  glyph_mask;
  int unsigned org_x, org_y, cell_sh;
  int unsigned col_pos, row_pos, depth_pos, sub_pos;

  pixel_result_t expected_pixels[$];
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int items_sent     = 0;
  int writes_seen    = 0;
  int walks_done     = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the result of one accepted item and advances the walk.
  task automatic predict_pixel(input logic act, input logic [5:0] code,
                               input logic [9:0] ox, input logic [9:0] oy,
                               input logic [2:0] sh);
    pixel_result_t res;
    int unsigned   gsize, cell_no, fx, fy, grey;
    res = '{we: 1'b0, idx: '0, color: '0, done: 1'b0};
    if (act == egr_pkg::ACT_START) begin
      glyph_mask = GLYPH_TABLE[code];
      org_x      = ox;
      org_y      = oy;
      cell_sh    = (sh > SHIFT_CAP) ? SHIFT_CAP : sh;
      col_pos    = 0;
      row_pos    = 0;
      depth_pos  = 0;
      sub_pos    = 0;
      walk_busy  = 1'b1;
    end else if (walk_busy) begin
      gsize   = (3 << cell_sh) - 1;
      cell_no = (col_pos >> cell_sh) + 3 * (row_pos >> cell_sh);
      if (cell_no < 9 && glyph_mask[cell_no]) begin
        fx      = org_x + col_pos + 2 * depth_pos;
        fy      = org_y + row_pos - (col_pos >> 2) + 2 * depth_pos + sub_pos;
        res.we  = 1'b1;
        res.idx = fx + fy * FB_PITCH;
        if (depth_pos == 0) begin
          res.color = WHITE;
        end else begin
          grey      = (3 * depth_pos > GREY_BASE) ? 0 : GREY_BASE - 3 * depth_pos;
          res.color = {grey[7:0], grey[7:0], grey[7:0]};
        end
        // Bottom rows of the glyph are shaded dark.
        if (gsize >= 3 && row_pos > gsize - 3) begin
          res.color = DARK_GREY;
        end
      end
      // Advance sub-row, depth, row, then column.
      sub_pos++;
      if (sub_pos >= SUBROW_COUNT) begin
        sub_pos = 0;
        depth_pos++;
        if (depth_pos * 4 >= DEPTH_END) begin
          depth_pos = 0;
          row_pos += ROW_STRIDE;
          if (row_pos >= gsize) begin
            row_pos = 0;
            col_pos++;
            if (col_pos >= gsize) begin
              col_pos   = 0;
              walk_busy = 1'b0;
              res.done  = 1'b1;
            end
          end
        end
      end
    end
    expected_pixels.push_back(res);
  endtask

  // Offers one item, holds it until accepted and records its prediction.
  task automatic send_item(input logic act, input logic [5:0] code,
                           input logic [9:0] ox, input logic [9:0] oy,
                           input logic [2:0] sh);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {3'b000, sh, oy, ox, code};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(act, code, ox, oy, sh);
    items_sent++;
  endtask

  task automatic send_start(input logic [5:0] code, input logic [9:0] ox,
                            input logic [9:0] oy, input logic [2:0] sh);
    send_item(egr_pkg::ACT_START, code, ox, oy, sh);
  endtask

  // Ticks carry random content in the fields that they do not use.
  task automatic send_ticks(input int count);
    repeat (count) begin
      send_item(egr_pkg::ACT_TICK, 6'($urandom), 10'($urandom), 10'($urandom),
                3'($urandom));
    end
  endtask

  // Ticks before any start must write nothing.
  task automatic test_idle_ticks();
    send_ticks(3);
  endtask

  // Field extremes, the empty glyph, scale saturation and restart while busy.
  task automatic test_directed();
    send_start(CODE_EMPTY, 10'd0, 10'd0, 3'd0);
    send_ticks(3);
    send_start(CODE_LAST, 10'd1023, 10'd1023, 3'd7);
    send_ticks(4);
    send_start(CODE_FULL, 10'd0, 10'd0, 3'd0);
    send_ticks(5);
    send_start(6'd1, 10'd512, 10'd341, 3'd6);
    send_start(6'd42, 10'd1023, 10'd0, 3'd3);
    send_ticks(5);
  endtask

  // A complete walk on the top row, through the depth clamp to the end:
  // columns four and up index above row zero and wrap.
  task automatic test_row_wrap();
    send_start(CODE_FULL, 10'($urandom), 10'd0, 3'd1);
    send_ticks(461);
  endtask

  // Scale 2 reaches the bottom row band with its dark shading.
  task automatic test_bottom_rows();
    send_start(6'd16, 10'($urandom), 10'($urandom), 3'd2);
    send_ticks(190);
  endtask

  // Mostly start-and-walk sequences with random content, some noise ticks.
  task automatic test_random(input int item_goal);
    int          goal;
    int unsigned pick;
    logic [2:0]  sh;
    goal = items_sent + item_goal;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 15) begin
        send_ticks($urandom_range(1, 5));
      end else begin
        pick = $urandom_range(9);
        if (pick < 4) sh = 3'd0;
        else if (pick < 7) sh = 3'd1;
        else if (pick < 9) sh = 3'd2;
        else sh = 3'($urandom_range(3, 7));
        send_start(6'($urandom), 10'($urandom), 10'($urandom), sh);
        send_ticks($urandom_range(0, 30));
      end
    end
  endtask

  // The receiver stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare every accepted result with the oldest prediction.
  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected result item: index %h color %h", out_tdata[31:0],
               out_tdata[55:32]);
        error_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (out_tuser !== want.we) begin
          $error("write_enable: expected %0d, got %0d", want.we, out_tuser);
          error_count++;
        end
        if (out_tdata[31:0] !== want.idx) begin
          $error("pixel_index: expected %h, got %h", want.idx, out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[55:32] !== want.color) begin
          $error("pixel_color: expected %h, got %h", want.color, out_tdata[55:32]);
          error_count++;
        end
        if (out_tlast !== want.done) begin
          $error("glyph_done: expected %0d, got %0d", want.done, out_tlast);
          error_count++;
        end
        if (want.we) writes_seen++;
        if (want.done) walks_done++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items with no idling.
    test_idle_ticks();
    test_directed();

    // Sender idle.
    send_idle_pct = 56;
    test_row_wrap();

    // Receiver stalling.
    send_idle_pct  = 0;
    recv_stall_pct = 56;
    test_bottom_rows();

    // Both sides idling.
    send_idle_pct  = 34;
    recv_stall_pct = 34;
    test_random(40);

    // Drain, then watch for stray results.
    in_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d start and tick items: restarts, scale saturation, a full walk",
             items_sent);
    $display("with row wrap and the bottom band, under four idling mixes: %0d writes, %0d walks.",
             writes_seen, walks_done);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #200us;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
design/egr_pkg.sv
design/egr_ctrl.sv
design/egr_datapath.sv
design/extruded_glyph_rasterizer.sv
verif/tb_top.sv
